// File: hdl/qte_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler angle unit.
`timescale 1ns / 1ps

package qte_pkg;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_READ_FAIL = 2'd1,
      STATUS_NO_QUAT   = 2'd2
   } status_type;

   typedef struct packed {
      logic               read_ok;
      logic               has_quat;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } qte_req_type;

   typedef struct packed {
      logic signed [14:0] pitch_angle;
      logic signed [15:0] roll_angle;
      logic signed [15:0] yaw_angle;
      status_type         status;
   } qte_rsp_type;

   // vector width into the atan2 pipes, and internal CORDIC width (gain headroom)
   localparam int VEC_W    = 36;
   localparam int CORDIC_W = 40;

   // square root: 61-bit radicand, one result bit per stage
   localparam int SQRT_W      = 61;
   localparam int SQRT_STAGES = 31;
   localparam int ROOT_W      = 31;

   localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
   localparam logic signed [35:0] PI_Q30  = 36'sd3373259426;
   localparam logic [SQRT_W-1:0]  ONE_SQ  = SQRT_W'(1) << 60;

   // radians (Q30) to 1/128 degree: round(m * 36672 / (5 * 2^30))
   localparam logic [15:0] DEG_NUM  = 16'd36672;
   localparam logic [31:0] HALF_DEN = 32'd2684354560;
   localparam logic [21:0] RECIP5   = 22'd3355444;   // ceil(2^24 / 5)

   localparam int PITCH_LIM = 11521;
   localparam int TURN_LIM  = 23042;

   localparam logic signed [35:0] ATAN_HEAD [10] = '{
      36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
      36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
      36'sd4194282,   36'sd2097149
   };

   function automatic logic signed [35:0] atan_step(input int i);
      logic signed [35:0] r;
      if (i < 10) begin
         r = ATAN_HEAD[i[3:0]];
      end else if (i < 30) begin
         r = (36'sd1 <<< (30 - i)) - 36'sd1;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // 2*a*b in Q30 from the exact Q60 product, floor rounding
   function automatic logic signed [34:0] twice_prod(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 29;
      return s[34:0];
   endfunction

endpackage

// File: hdl/quaternion_to_euler_angles_unit.sv
// Top level: quaternion (Q30) to ZYX Euler angles in 1/128 degree, fully pipelined.
`timescale 1ns / 1ps

// One transaction enters per clock: start is taken whenever it is high, since
// busy is tied low. Every transaction yields exactly one result, shown on rsp_data
// for a single cycle with rsp_valid high; the receiver cannot hold it off, so it
// must take every strobe. The path runs through the capture, product, sum and square
// registers, the 31-stage square-root pipe for the pitch cosine, the CORDIC atan2
// pipes (one rotation per stage), the unit conversion and the output register.
// Status: 0 ok, 1 read failed, 2 no quaternion; on a nonzero status all angles
// read zero. The pitch sine is saturated to +/-1 before the cosine is formed.
module quaternion_to_euler_angles_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qte_pkg::qte_req_type req_data,
   output logic                 rsp_valid,
   output qte_pkg::qte_rsp_type rsp_data
);
   import qte_pkg::*;

   localparam int STEPS    = (CORDIC_STEPS < 62) ? CORDIC_STEPS : 62;
   localparam int ATAN_LAT = STEPS + 4;
   localparam int LATENCY  = STEPS + 40;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] sp;
      logic signed [35:0] roll_y;
      logic signed [35:0] roll_x;
      logic signed [35:0] yaw_y;
      logic signed [35:0] yaw_x;
   } side_type;

   // the pipe never stalls
   assign busy = 1'b0;

   // ---- stage 0: capture transaction
   logic        in_valid_ff;
   qte_req_type in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_data_ff <= req_data;
   end

   // ---- stage 1: the nine component products, plus status
   logic signed [63:0] p_wy_ff, p_xz_ff, p_yz_ff, p_wx_ff, p_xy_ff, p_wz_ff;
   logic signed [63:0] p_xx_ff, p_yy_ff, p_zz_ff;
   logic               st1_valid_ff;
   status_type         st1_status_ff, st1_status_in;

   always_comb begin
      if (!in_data_ff.read_ok) begin
         st1_status_in = STATUS_READ_FAIL;
      end else if (!in_data_ff.has_quat) begin
         st1_status_in = STATUS_NO_QUAT;
      end else begin
         st1_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= in_valid_ff;
      end
      st1_status_ff <= st1_status_in;
      p_wy_ff <= in_data_ff.quat_w * in_data_ff.quat_y;
      p_xz_ff <= in_data_ff.quat_x * in_data_ff.quat_z;
      p_yz_ff <= in_data_ff.quat_y * in_data_ff.quat_z;
      p_wx_ff <= in_data_ff.quat_w * in_data_ff.quat_x;
      p_xy_ff <= in_data_ff.quat_x * in_data_ff.quat_y;
      p_wz_ff <= in_data_ff.quat_w * in_data_ff.quat_z;
      p_xx_ff <= in_data_ff.quat_x * in_data_ff.quat_x;
      p_yy_ff <= in_data_ff.quat_y * in_data_ff.quat_y;
      p_zz_ff <= in_data_ff.quat_z * in_data_ff.quat_z;
   end

   // ---- stage 2: sums, pitch sine saturation
   logic signed [35:0] sp_wide;
   side_type           st2_in, st2_ff;
   logic               st2_valid_ff;

   always_comb begin
      sp_wide = 36'(twice_prod(p_wy_ff)) - 36'(twice_prod(p_xz_ff));
      st2_in.status = st1_status_ff;
      if (sp_wide > ONE_Q30) begin
         st2_in.sp = ONE_Q30[31:0];
      end else if (sp_wide < -ONE_Q30) begin
         st2_in.sp = 32'(-ONE_Q30);
      end else begin
         st2_in.sp = sp_wide[31:0];
      end
      st2_in.roll_y = 36'(twice_prod(p_yz_ff)) + 36'(twice_prod(p_wx_ff));
      st2_in.roll_x = ONE_Q30 - 36'(twice_prod(p_xx_ff)) - 36'(twice_prod(p_yy_ff));
      st2_in.yaw_y  = 36'(twice_prod(p_xy_ff)) + 36'(twice_prod(p_wz_ff));
      st2_in.yaw_x  = ONE_Q30 - 36'(twice_prod(p_yy_ff)) - 36'(twice_prod(p_zz_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else begin
         st2_valid_ff <= st1_valid_ff;
      end
      st2_ff <= st2_in;
   end

   // ---- stage 3: sine squared
   logic signed [63:0] sq_full;
   logic [SQRT_W-1:0]  sq_ff;
   side_type           st3_ff;
   logic               st3_valid_ff;

   assign sq_full = st2_ff.sp * st2_ff.sp;

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end else begin
         st3_valid_ff <= st2_valid_ff;
      end
      sq_ff  <= sq_full[SQRT_W-1:0];
      st3_ff <= st2_ff;
   end

   // ---- cosine = sqrt(1 - sine^2); side data rides a matching delay line
   logic              sq_valid;
   logic [ROOT_W-1:0] cp_root;
   side_type          side_dl_ff [0:SQRT_STAGES-1];

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st3_valid_ff),
      .in_value  (ONE_SQ - sq_ff),
      .out_valid (sq_valid),
      .out_root  (cp_root)
   );

   always_ff @(posedge clock) begin
      side_dl_ff[0] <= st3_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         side_dl_ff[k] <= side_dl_ff[k-1];
      end
   end

   side_type side_out;
   assign side_out = side_dl_ff[SQRT_STAGES-1];

   // ---- three atan2 pipes
   logic                     pitch_v, roll_v, yaw_v;
   logic signed [14:0]       pitch_a;
   logic signed [15:0]       roll_a, yaw_a;

   qte_atan2 #(.STEPS(STEPS), .LIMIT(PITCH_LIM), .OUT_W(15)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_y      (VEC_W'(side_out.sp)),
      .in_x      ($signed({5'd0, cp_root})),
      .out_valid (pitch_v),
      .out_angle (pitch_a)
   );

   qte_atan2 #(.STEPS(STEPS), .LIMIT(TURN_LIM), .OUT_W(16)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_y      (side_out.roll_y),
      .in_x      (side_out.roll_x),
      .out_valid (roll_v),
      .out_angle (roll_a)
   );

   qte_atan2 #(.STEPS(STEPS), .LIMIT(TURN_LIM), .OUT_W(16)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_y      (side_out.yaw_y),
      .in_x      (side_out.yaw_x),
      .out_valid (yaw_v),
      .out_angle (yaw_a)
   );

   // status follows the atan2 latency
   status_type status_dl_ff [0:ATAN_LAT-1];

   always_ff @(posedge clock) begin
      status_dl_ff[0] <= side_out.status;
      for (int k = 1; k < ATAN_LAT; k++) begin
         status_dl_ff[k] <= status_dl_ff[k-1];
      end
   end

   // ---- output register; angles forced to zero on a failed transaction
   logic        rsp_valid_ff;
   qte_rsp_type rsp_data_ff, rsp_data_in;
   status_type  st_out;

   always_comb begin
      st_out = status_dl_ff[ATAN_LAT-1];
      rsp_data_in.status = st_out;
      if (st_out == STATUS_OK) begin
         rsp_data_in.pitch_angle = pitch_a;
         rsp_data_in.roll_angle  = roll_a;
         rsp_data_in.yaw_angle   = yaw_a;
      end else begin
         rsp_data_in.pitch_angle = '0;
         rsp_data_in.roll_angle  = '0;
         rsp_data_in.yaw_angle   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pitch_v;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (pitch_v == roll_v) && (roll_v == yaw_v))
      else $error("atan2 lanes out of step");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |->
         (rsp_data.pitch_angle == '0) && (rsp_data.roll_angle == '0) &&
         (rsp_data.yaw_angle == '0))
      else $error("nonzero angle on failed transaction");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pitch_angle <= 15'sd11521) &&
                    (rsp_data.pitch_angle >= -15'sd11521))
      else $error("pitch out of range");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("result missing at fixed latency");
`endif

endmodule

// File: hdl/qte_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module qte_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [qte_pkg::SQRT_W-1:0] in_value,
   output logic                      out_valid,
   output logic [qte_pkg::ROOT_W-1:0] out_root
);
   import qte_pkg::*;

   logic [SQRT_W-1:0] rem_w [0:SQRT_STAGES];
   logic [SQRT_W:0]   res_w [0:SQRT_STAGES];
   logic              val_w [0:SQRT_STAGES];

   logic [SQRT_W-1:0] rem_ff [0:SQRT_STAGES-1];
   logic [SQRT_W:0]   res_ff [0:SQRT_STAGES-1];
   logic              val_ff [0:SQRT_STAGES-1];

   assign rem_w[0] = in_value;
   assign res_w[0] = '0;
   assign val_w[0] = in_valid;

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQRT_W:0] BIT = (SQRT_W+1)'(1) << (60 - 2 * k);
      logic [SQRT_W:0]   trial;
      logic [SQRT_W-1:0] rem_in;
      logic [SQRT_W:0]   res_in;

      always_comb begin
         trial = res_w[k] + BIT;
         if ({1'b0, rem_w[k]} >= trial) begin
            rem_in = rem_w[k] - trial[SQRT_W-1:0];
            res_in = (res_w[k] >> 1) + BIT;
         end else begin
            rem_in = rem_w[k];
            res_in = res_w[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else begin
            val_ff[k] <= val_w[k];
         end
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
      end

      assign rem_w[k+1] = rem_ff[k];
      assign res_w[k+1] = res_ff[k];
      assign val_w[k+1] = val_ff[k];
   end

   assign out_valid = val_w[SQRT_STAGES];
   assign out_root  = res_w[SQRT_STAGES][ROOT_W-1:0];

endmodule

// File: hdl/qte_atan2.sv
// Pipelined CORDIC atan2 with conversion to clamped 1/128 degree units.
`timescale 1ns / 1ps

module qte_atan2 #(
   parameter int STEPS = 16,
   parameter int LIMIT = 23042,
   parameter int OUT_W = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [qte_pkg::VEC_W-1:0] in_y,
   input  logic signed [qte_pkg::VEC_W-1:0] in_x,
   output logic                            out_valid,
   output logic signed [OUT_W-1:0]         out_angle
);
   import qte_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [0:STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:STEPS];
   logic signed [35:0]         z_ff [0:STEPS];
   logic                       zero_ff [0:STEPS];
   logic                       val_ff [0:STEPS];

   // prelude: fold left half-plane onto the right, seed angle with +/-pi
   logic signed [CORDIC_W-1:0] xe, ye;
   logic signed [CORDIC_W-1:0] x0_in, y0_in;
   logic signed [35:0]         z0_in;
   logic                       zero0_in;

   always_comb begin
      xe       = CORDIC_W'(in_x);
      ye       = CORDIC_W'(in_y);
      zero0_in = (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
         x0_in = -xe;
         y0_in = -ye;
         z0_in = (in_y >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         x0_in = xe;
         y0_in = ye;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else begin
         val_ff[0] <= in_valid;
      end
      x_ff[0]    <= x0_in;
      y_ff[0]    <= y0_in;
      z_ff[0]    <= z0_in;
      zero_ff[0] <= zero0_in;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [35:0] ANG = atan_step(i);
      logic signed [CORDIC_W-1:0] x_in, y_in;
      logic signed [35:0]         z_in;

      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ANG;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i+1] <= 1'b0;
         end else begin
            val_ff[i+1] <= val_ff[i];
         end
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   // unit conversion: scale-and-round, divide by 5 via reciprocal, clamp
   logic               c1_val_ff, c2_val_ff, c3_val_ff;
   logic               c1_neg_ff, c2_neg_ff;
   logic [52:0]        t_ff;
   logic [45:0]        qf_ff;
   logic signed [OUT_W-1:0] ang_ff;

   logic signed [35:0] zf;
   logic               neg_in;
   logic [35:0]        m;
   logic [52:0]        t_in;
   logic [22:0]        u;
   logic [45:0]        qf_in;
   logic [21:0]        q, qc;
   logic signed [OUT_W-1:0] ang_in;

   always_comb begin
      zf     = zero_ff[STEPS] ? 36'sd0 : z_ff[STEPS];
      neg_in = zf < 0;
      m      = neg_in ? 36'(-zf) : 36'(zf);
      t_in   = 53'(m) * 53'(DEG_NUM) + 53'(HALF_DEN);
      u      = t_ff[52:30];
      qf_in  = 46'(u) * 46'(RECIP5);
      q      = qf_ff[45:24];
      qc     = (q > 22'(LIMIT)) ? 22'(LIMIT) : q;
      ang_in = c2_neg_ff ? -OUT_W'(qc) : OUT_W'(qc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_val_ff <= 1'b0;
         c2_val_ff <= 1'b0;
         c3_val_ff <= 1'b0;
      end else begin
         c1_val_ff <= val_ff[STEPS];
         c2_val_ff <= c1_val_ff;
         c3_val_ff <= c2_val_ff;
      end
      t_ff      <= t_in;
      c1_neg_ff <= neg_in;
      qf_ff     <= qf_in;
      c2_neg_ff <= c1_neg_ff;
      ang_ff    <= ang_in;
   end

   assign out_valid = c3_val_ff;
   assign out_angle = ang_ff;

endmodule
